[rtl/retro_video_raster_generator_top_defines.svh]
// Assertion macros shared by the raster generator RTL.
`ifndef RETRO_VIDEO_RASTER_GENERATOR_TOP_DEFINES_SVH
`define RETRO_VIDEO_RASTER_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RVRG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvrg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RVRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvrg: next-cycle check failed");

`endif

[rtl/rvrg_pkg.sv]
// Types and constants shared by the raster generator modules.
package rvrg_pkg;

	localparam int ADDR_W     = 13;
	localparam int DATA_W     = 8;
	localparam int COLOR_W    = 32;
	localparam int PADDR_W    = 19;
	localparam int ATTR_IDX_W = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int Q_DEPTH    = 4;

	// Bitmap occupies the store below the attribute base
	localparam logic [ADDR_W-1:0] ATTR_BASE = 13'h1800;
	localparam int BMP_BYTES = 6144;

	// Item operations
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BORDER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_BORDER     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_TOTAL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_PERIOD     = 3'd6;

	// Color component levels
	localparam logic [7:0] COMP_BRIGHT = 8'hFF;
	localparam logic [7:0] COMP_NORMAL = 8'hBB;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// One queued job: a store write or a visible pixel
	typedef struct packed {
		logic                  op;
		logic                  in_screen;
		logic                  fetch;
		logic                  flash;
		logic                  bar;
		logic [ADDR_W-1:0]     addr;
		logic [ATTR_IDX_W-1:0] attr_idx;
		logic [DATA_W-1:0]     data;
		logic [PADDR_W-1:0]    paddr;
	} q_entry_t;

endpackage

[rtl/rvrg_if.sv]
// Channel interfaces: input items, output pixels, configuration writes.
interface rvrg_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [12:0] write_address;
	logic [7:0]  write_data;

	modport source (output valid, operation, write_address, write_data, input ready);
	modport sink (input valid, operation, write_address, write_data, output ready);
endinterface

interface rvrg_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_color;
	logic [18:0] pixel_address;

	modport source (output valid, pixel_color, pixel_address, input ready);
	modport sink (input valid, pixel_color, pixel_address, output ready);
endinterface

interface rvrg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/rvrg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rvrg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/rvrg_queue.sv]
// Short job queue between the beam front end and the pixel back end.
module rvrg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rvrg_pkg::q_entry_t push_data,
	input  logic               pop,
	output rvrg_pkg::q_entry_t head,
	output logic               full,
	output logic               empty
);
	import rvrg_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	q_entry_t           slot_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/rvrg_front.sv]
// Front end: config registers, beam counters, item classification.
module rvrg_front #(
	parameter int STORE_BYTES = 6912
) (
	input  logic               clk,
	input  logic               arst_n,
	rvrg_item_if.sink          item,
	rvrg_cfg_if.sink           cfg,
	input  logic               clr_busy,
	input  logic               q_full,
	output logic               q_push,
	output rvrg_pkg::q_entry_t q_entry
);
	import rvrg_pkg::*;

	// Configuration registers
	logic [8:0]  left_q;
	logic [7:0]  top_q;
	logic [9:0]  vis_w_q;
	logic [8:0]  vis_h_q;
	logic [9:0]  line_tot_q;
	logic [8:0]  frame_tot_q;
	logic [15:0] bar_per_q;

	// Beam state
	logic [9:0]         col_q;
	logic [8:0]         line_q;
	logic [PADDR_W-1:0] paddr_q;
	logic [4:0]         frame_q;
	logic [15:0]        bar_cnt_q;
	logic               bar_q;

	logic        accept;
	logic        tick;
	logic        visible;
	logic        scr_x;
	logic        scr_y;
	logic [9:0]  rel;
	logic [7:0]  vpos;
	logic [4:0]  hcell;
	logic [10:0] col_nx;
	logic [9:0]  line_nx;
	logic [16:0] bar_nx;
	logic        line_wrap;
	logic        frame_wrap;
	logic        bar_wrap;
	logic        wr_ok;

	assign cfg.ready  = 1'b1;
	assign item.ready = !clr_busy && !q_full;
	assign accept     = item.valid && item.ready;
	assign tick       = accept && (item.operation == OP_TICK);

	// Classify the beam position
	always_comb begin
		visible = (col_q < vis_w_q) && (line_q < vis_h_q);
		scr_x   = ({1'b0, col_q} >= {2'b0, left_q}) &&
		          ({1'b0, col_q} < ({2'b0, left_q} + 11'd256));
		scr_y   = ({1'b0, line_q} >= {2'b0, top_q}) &&
		          ({1'b0, line_q} < ({2'b0, top_q} + 10'd192));
		rel     = col_q - {1'b0, left_q};
		vpos    = line_q[7:0] - top_q;
		hcell   = rel[7:3];
		col_nx  = {1'b0, col_q} + 11'd1;
		line_nx = {1'b0, line_q} + 10'd1;
		bar_nx  = {1'b0, bar_cnt_q} + 17'd1;
		line_wrap  = (col_nx >= {1'b0, line_tot_q});
		frame_wrap = line_wrap && (line_nx >= {1'b0, frame_tot_q});
		bar_wrap   = (bar_nx >= {1'b0, bar_per_q});
		wr_ok      = ({1'b0, item.write_address} < 14'(STORE_BYTES));
	end

	// Build the queue entry
	always_comb begin
		q_entry.op        = item.operation;
		q_entry.in_screen = scr_x && scr_y;
		q_entry.fetch     = (rel[2:0] == 3'd0);
		q_entry.flash     = frame_q[4];
		q_entry.bar       = bar_q;
		q_entry.attr_idx  = {vpos[7:3], hcell};
		q_entry.data      = item.write_data;
		q_entry.paddr     = paddr_q;
		if (item.operation == OP_WRITE) begin
			q_entry.addr = item.write_address;
		end else begin
			q_entry.addr = {vpos[7:6], vpos[2:0], vpos[5:3], hcell};
		end
		if (item.operation == OP_WRITE) begin
			q_push = accept && wr_ok;
		end else begin
			q_push = accept && visible;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= 9'd48;
			top_q       <= 8'd48;
			vis_w_q     <= 10'd352;
			vis_h_q     <= 9'd288;
			line_tot_q  <= 10'd448;
			frame_tot_q <= 9'd312;
			bar_per_q   <= 16'd1024;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LEFT_BORDER:    left_q      <= cfg.data[8:0];
				CFG_TOP_BORDER:     top_q       <= cfg.data[7:0];
				CFG_VISIBLE_WIDTH:  vis_w_q     <= cfg.data[9:0];
				CFG_VISIBLE_HEIGHT: vis_h_q     <= cfg.data[8:0];
				CFG_LINE_TOTAL:     line_tot_q  <= cfg.data[9:0];
				CFG_FRAME_TOTAL:    frame_tot_q <= cfg.data[8:0];
				CFG_BAR_PERIOD:     bar_per_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance the beam and bar timer on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			line_q    <= '0;
			paddr_q   <= '0;
			frame_q   <= '0;
			bar_cnt_q <= '0;
			bar_q     <= 1'b0;
		end else if (tick) begin
			if (line_wrap) begin
				col_q <= '0;
				if (frame_wrap) begin
					line_q  <= '0;
					frame_q <= frame_q + 1'b1;
				end else begin
					line_q <= line_nx[8:0];
				end
			end else begin
				col_q <= col_nx[9:0];
			end
			if (frame_wrap) begin
				paddr_q <= '0;
			end else if (visible) begin
				paddr_q <= paddr_q + 1'b1;
			end
			if (bar_wrap) begin
				bar_cnt_q <= '0;
				bar_q     <= !bar_q;
			end else begin
				bar_cnt_q <= bar_nx[15:0];
			end
		end
	end

endmodule

[rtl/rvrg_back.sv]
// Back end: screen store, clearing pass, cell fetch and pixel coloring.
module rvrg_back #(
	parameter int STORE_BYTES = 6912
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rvrg_pkg::q_entry_t head,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               clr_busy,
	rvrg_pixel_if.source       pixel
);
	import rvrg_pkg::*;

	localparam int ATTR_DEPTH = STORE_BYTES - BMP_BYTES;
	localparam int BMP_AW     = $clog2(BMP_BYTES);
	localparam int ATTR_AW    = $clog2(ATTR_DEPTH);

	logic               clr_busy_q;
	logic [ADDR_W-1:0]  clr_cnt_q;

	logic               valid_s1;
	q_entry_t           ent_s1;
	logic               out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [PADDR_W-1:0] paddr_q;
	logic [7:0]         shift_q;
	logic [7:0]         attr_q;

	logic               adv;
	logic               head_wr;
	logic               head_tick;
	logic [ADDR_W-1:0]  attr_off;
	logic               bmp_we;
	logic               attr_we;
	logic [BMP_AW-1:0]  bmp_waddr;
	logic [ATTR_AW-1:0] attr_waddr;
	logic [7:0]         wdata;
	logic               rd_en;
	logic [7:0]         bmp_rdata;
	logic [7:0]         attr_rdata;
	logic [7:0]         shift_cur;
	logic [7:0]         attr_cur;
	logic               ink;
	logic               red;
	logic               green;
	logic               blue;
	logic [7:0]         comp;

	assign clr_busy  = clr_busy_q;
	assign adv       = valid_s1 && (!out_valid_q || pixel.ready);
	assign q_pop     = !q_empty && !clr_busy_q && (!valid_s1 || adv);
	assign head_wr   = q_pop && (head.op == OP_WRITE);
	assign head_tick = q_pop && (head.op == OP_TICK);
	assign rd_en     = head_tick && head.in_screen && head.fetch;
	assign attr_off  = head.addr - ATTR_BASE;

	// Route store writes, or zeros during the clearing pass
	always_comb begin
		if (clr_busy_q) begin
			bmp_we     = 1'b1;
			attr_we    = ({1'b0, clr_cnt_q} < 14'(ATTR_DEPTH));
			bmp_waddr  = clr_cnt_q[BMP_AW-1:0];
			attr_waddr = clr_cnt_q[ATTR_AW-1:0];
			wdata      = '0;
		end else begin
			bmp_we     = head_wr && (head.addr < ATTR_BASE);
			attr_we    = head_wr && (head.addr >= ATTR_BASE);
			bmp_waddr  = head.addr[BMP_AW-1:0];
			attr_waddr = attr_off[ATTR_AW-1:0];
			wdata      = head.data;
		end
	end

	rvrg_ram #(
		.WIDTH (8),
		.DEPTH (BMP_BYTES)
	) u_bmp_ram (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (bmp_waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (head.addr[BMP_AW-1:0]),
		.rdata (bmp_rdata)
	);

	rvrg_ram #(
		.WIDTH (8),
		.DEPTH (ATTR_DEPTH)
	) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.waddr (attr_waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (ATTR_AW'(head.attr_idx)),
		.rdata (attr_rdata)
	);

	// Step the clearing pass over the store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == ADDR_W'(BMP_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Pixel color from the fetched or shifted cell
	always_comb begin
		shift_cur = ent_s1.fetch ? bmp_rdata : shift_q;
		attr_cur  = ent_s1.fetch ? attr_rdata : attr_q;
		ink       = (attr_cur[7] && ent_s1.flash) ^ shift_cur[7];
		if (ent_s1.in_screen) begin
			red   = ink ? attr_cur[1] : attr_cur[4];
			green = ink ? attr_cur[2] : attr_cur[5];
			blue  = ink ? attr_cur[0] : attr_cur[3];
			comp  = attr_cur[6] ? COMP_BRIGHT : COMP_NORMAL;
		end else begin
			red   = ent_s1.bar;
			green = !ent_s1.bar;
			blue  = !ent_s1.bar;
			comp  = COMP_NORMAL;
		end
	end

	// Hold the pixel job whose store read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (head_tick) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_tick) begin
			ent_s1 <= head;
		end
	end

	// Shift register and attribute of the current cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			attr_q  <= '0;
		end else if (adv && ent_s1.in_screen) begin
			shift_q <= {shift_cur[6:0], 1'b0};
			attr_q  <= attr_cur;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			color_q <= {ALPHA_OPAQUE, blue ? comp : 8'h00, green ? comp : 8'h00,
			            red ? comp : 8'h00};
			paddr_q <= ent_s1.paddr;
		end
	end

	assign pixel.valid         = out_valid_q;
	assign pixel.pixel_color   = color_q;
	assign pixel.pixel_address = paddr_q;

endmodule

[rtl/retro_video_raster_generator_top.sv]
// Top level of the raster generator: front end, job queue, back end.
//
//   channel  dir  beat contents
//   item     in   operation, write_address, write_data
//   pixel    out  pixel_color, pixel_address
//   cfg      in   index, data (register write, always ready)
//
// One item per cycle sustained while the queue has room and no clearing pass runs;
// a visible tick reaches the pixel output through the queue write, store read and output register.
// After reset a clearing pass writes zero to all 6144 bitmap entries, one
// bitmap entry a cycle, the attribute entries alongside the first ones;
// item is not ready meanwhile.
// A pixel stall fills the four-entry queue, then item.ready drops.
// Invisible ticks and out-of-range writes retire in the front end.
module retro_video_raster_generator_top #(
	parameter int STORE_BYTES = 6912
) (
	input  logic         clk,
	input  logic         arst_n,
	rvrg_item_if.sink    item,
	rvrg_pixel_if.source pixel,
	rvrg_cfg_if.sink     cfg
);
	import rvrg_pkg::*;

	`include "retro_video_raster_generator_top_defines.svh"

	q_entry_t q_entry;
	q_entry_t q_head;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	logic     clr_busy;

	rvrg_front #(
		.STORE_BYTES (STORE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.clr_busy (clr_busy),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	rvrg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rvrg_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.clr_busy (clr_busy),
		.pixel    (pixel)
	);

	// Checks on queue and clearing interplay
	`RVRG_ASSERT_NOW(a_no_item_in_clear, item.valid && item.ready, !clr_busy)
	`RVRG_ASSERT_NOW(a_no_push_full, q_push, !q_full)
	`RVRG_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty)
	`RVRG_ASSERT_NOW(a_clear_queue_empty, clr_busy, q_empty && !q_pop)
	`RVRG_ASSERT_NEXT(a_clear_once, $fell(clr_busy), !clr_busy)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the raster generator: beam item stimulus, pixel prediction, checks.
module tb_top;
	import rvrg_pkg::*;

	localparam int STORE_BYTES     = 6912;
	localparam int CLK_HALF_NS     = 2;
	localparam int RESET_CYCLES    = 12;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RUN_LIMIT_NS    = 2_000_000;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} beam_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [PADDR_W-1:0] paddr;
	} pixel_t;

	typedef enum {PH_SMALL, PH_DEEP, PH_MAX, PH_ZERO, PH_MIN, PH_RESET} raster_setup_t;

	logic clk = 1'b0;
	logic arst_n;

	rvrg_item_if  item_ch ();
	rvrg_pixel_if pix_ch ();
	rvrg_cfg_if   cfg_ch ();

	retro_video_raster_generator_top #(.STORE_BYTES(STORE_BYTES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.pixel(pix_ch),
		.cfg(cfg_ch)
	);

	// Free-running pixel clock
	always #(CLK_HALF_NS) clk = ~clk;

	// Shadow of the screen store, beam counters and timing registers
	logic [DATA_W-1:0]  screen_mem [STORE_BYTES];
	logic [9:0]         beam_col;
	logic [8:0]         beam_line;
	logic [PADDR_W-1:0] fb_addr;
	logic [4:0]         frame_no;
	logic [7:0]         shift_reg;
	logic [7:0]         attr_reg;
	logic [15:0]        bar_cnt;
	logic               bar_red;
	logic [8:0]         left_b;
	logic [7:0]         top_b;
	logic [9:0]         vis_w;
	logic [8:0]         vis_h;
	logic [9:0]         line_tot;
	logic [8:0]         frame_tot;
	logic [15:0]        bar_per;

	beam_item_t item_backlog [$];
	pixel_t     due_pixels [$];
	beam_item_t offer_item;
	pixel_t     due_px;
	int         err_count = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         hold_left = 0;
	int         stall_step = 0;
	int         stall_mode = 0;
	logic       hold_req = 1'b0;
	logic       hold_done = 1'b0;

	raster_setup_t phase_plan [11] = '{PH_SMALL, PH_DEEP, PH_SMALL, PH_MAX, PH_SMALL, PH_ZERO,
		PH_SMALL, PH_RESET, PH_SMALL, PH_MIN, PH_SMALL};

	// Apply one accepted item: store write, or beam tick with its pixel when visible
	task automatic trace_beam(input beam_item_t it);
		int unsigned col, row, rel, v, h, pa, nxt;
		logic pix_on, ink_on, red, green, blue, bright;
		logic [7:0] lvl;
		pixel_t px;
		if (it.op == OP_WRITE) begin
			if (it.addr < STORE_BYTES)
				screen_mem[it.addr] = it.data;
			return;
		end
		col = 32'(beam_col);
		row = 32'(beam_line);
		if (beam_col < vis_w && beam_line < vis_h) begin
			if (col >= left_b && col < left_b + 256 && row >= top_b && row < top_b + 192) begin
				rel = col - left_b;
				v = row - top_b;
				h = (rel >> 3) & 'h1F;
				// load a new cell at each eighth column of the screen area
				if ((rel & 7) == 0) begin
					pa = (((v & 'hC0) | ((v & 7) << 3) | ((v & 'h38) >> 3)) << 5) | h;
					shift_reg = (pa < STORE_BYTES) ? screen_mem[pa] : '0;
					pa = ATTR_BASE | ((v >> 3) << 5) | h;
					attr_reg = (pa < STORE_BYTES) ? screen_mem[pa] : '0;
				end
				pix_on = shift_reg[7];
				shift_reg = shift_reg << 1;
				ink_on = (attr_reg[7] && frame_no[4]) ? !pix_on : pix_on;
				red = ink_on ? attr_reg[1] : attr_reg[4];
				green = ink_on ? attr_reg[2] : attr_reg[5];
				blue = ink_on ? attr_reg[0] : attr_reg[3];
				bright = attr_reg[6];
			end else begin
				red = bar_red;
				green = !bar_red;
				blue = !bar_red;
				bright = 1'b0;
			end
			lvl = bright ? COMP_BRIGHT : COMP_NORMAL;
			px.color = {ALPHA_OPAQUE, blue ? lvl : 8'h00, green ? lvl : 8'h00, red ? lvl : 8'h00};
			px.paddr = fb_addr;
			fb_addr = fb_addr + 1'b1;
			due_pixels.push_back(px);
		end
		// advance column, line and frame
		nxt = col + 1;
		if (nxt >= line_tot || nxt > 'h3FF) begin
			beam_col = '0;
			nxt = row + 1;
			if (nxt >= frame_tot || nxt > 'h1FF) begin
				beam_line = '0;
				fb_addr = '0;
				frame_no = frame_no + 1'b1;
			end else begin
				beam_line = nxt[8:0];
			end
		end else begin
			beam_col = nxt[9:0];
		end
		// advance the border bar timer
		nxt = bar_cnt + 1;
		if (nxt >= bar_per || nxt > 'hFFFF) begin
			bar_cnt = '0;
			bar_red = ~bar_red;
		end else begin
			bar_cnt = nxt[15:0];
		end
	endtask

	// Write one timing register and mirror it into the shadow
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_LEFT_BORDER: left_b = value[8:0];
			CFG_TOP_BORDER: top_b = value[7:0];
			CFG_VISIBLE_WIDTH: vis_w = value[9:0];
			CFG_VISIBLE_HEIGHT: vis_h = value[8:0];
			CFG_LINE_TOTAL: line_tot = value[9:0];
			CFG_FRAME_TOTAL: frame_tot = value[8:0];
			CFG_BAR_PERIOD: bar_per = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(input int unsigned lb, tp, vw, vh, lt, ft, bp);
		write_reg(CFG_LEFT_BORDER, lb);
		write_reg(CFG_TOP_BORDER, tp);
		write_reg(CFG_VISIBLE_WIDTH, vw);
		write_reg(CFG_VISIBLE_HEIGHT, vh);
		write_reg(CFG_LINE_TOTAL, lt);
		write_reg(CFG_FRAME_TOTAL, ft);
		write_reg(CFG_BAR_PERIOD, bp);
	endtask

	task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		beam_item_t it;
		it.op = OP_WRITE;
		it.addr = addr;
		it.data = data;
		item_backlog.push_back(it);
	endtask

	// Queue random items; writes lean toward the cells the small windows show
	task automatic queue_random(input int count, input int wr_pct);
		beam_item_t it;
		int unsigned pick;
		repeat (count) begin
			it.op = ($urandom_range(99) < wr_pct) ? OP_WRITE : OP_TICK;
			it.data = DATA_W'($urandom_range(255));
			pick = $urandom_range(99);
			if (pick < 30)
				it.addr = ADDR_W'(($urandom_range(7) << 8) | $urandom_range(7));
			else if (pick < 45)
				it.addr = ADDR_W'(ATTR_BASE | $urandom_range(7));
			else if (pick < 60)
				it.addr = ADDR_W'($urandom_range(BMP_BYTES - 1) & 'h1FE0);
			else if (pick < 70)
				it.addr = ADDR_W'(ATTR_BASE | ($urandom_range(23) << 5));
			else if (pick < 80)
				it.addr = ADDR_W'($urandom_range(8191, STORE_BYTES));
			else
				it.addr = ADDR_W'($urandom_range(8191));
			item_backlog.push_back(it);
		end
	endtask

	// Hold until every item is taken and every pixel seen, then let stragglers retire
	task automatic wait_idle();
		while (item_backlog.size() != 0 || item_ch.valid || due_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Item driver: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.operation <= OP_TICK;
			item_ch.write_address <= '0;
			item_ch.write_data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				trace_beam('{item_ch.operation, item_ch.write_address, item_ch.write_data});
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (item_backlog.size() > 0) begin
					offer_item = item_backlog.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.operation <= offer_item.op;
					item_ch.write_address <= offer_item.addr;
					item_ch.write_data <= offer_item.data;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(64, 1);
						gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off so the job queue fills and backs up the item side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_OFF_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Pixel monitor: check each beat, stall on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
			stall_step = 0;
			stall_mode = 0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				if (due_pixels.size() == 0) begin
					err_count++;
					$display("%0t: unexpected pixel, expected none, actual color %h address %h",
						$time, pix_ch.pixel_color, pix_ch.pixel_address);
				end else begin
					due_px = due_pixels.pop_front();
					if (pix_ch.pixel_color !== due_px.color) begin
						err_count++;
						$display("%0t: pixel_color expected %h actual %h", $time,
							due_px.color, pix_ch.pixel_color);
					end
					if (pix_ch.pixel_address !== due_px.paddr) begin
						err_count++;
						$display("%0t: pixel_address expected %h actual %h", $time,
							due_px.paddr, pix_ch.pixel_address);
					end
				end
			end
			stall_step++;
			if (stall_step % 96 == 0)
				stall_mode = $urandom_range(3);
			if (hold_left > 0) begin
				pix_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: pix_ch.ready <= 1'b1;
					1: pix_ch.ready <= 1'($urandom_range(1));
					2: pix_ch.ready <= ($urandom_range(9) != 0);
					default: pix_ch.ready <= (stall_step % 5 != 0);
				endcase
			end
		end
	end

	// Stimulus sequence
	initial begin
		int unsigned lt, ft;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_TICK;
		item_ch.write_address = '0;
		item_ch.write_data = '0;
		pix_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LEFT_BORDER;
		cfg_ch.data = '0;
		// shadow state as it stands after reset
		foreach (screen_mem[i])
			screen_mem[i] = '0;
		beam_col = '0;
		beam_line = '0;
		fb_addr = '0;
		frame_no = '0;
		shift_reg = '0;
		attr_reg = '0;
		bar_cnt = '0;
		bar_red = 1'b0;
		left_b = 9'd48;
		top_b = 8'd48;
		vis_w = 10'd352;
		vis_h = 9'd288;
		line_tot = 10'd448;
		frame_tot = 9'd312;
		bar_per = 16'd1024;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small window with blanked tail columns, bar toggling every third tick
		set_timing(0, 0, 12, 4, 16, 4, 3);
		push_write(13'd0, 8'hFF);
		push_write(13'd1, 8'hAA);
		push_write(ATTR_BASE, 8'h47);
		push_write(ATTR_BASE + 13'd1, 8'hB8);
		push_write(13'd256, 8'h0F);
		push_write(13'd6143, 8'h5A);
		push_write(13'd6911, 8'h80);
		push_write(13'd6912, 8'hFF);
		push_write(13'd8191, 8'h01);
		push_write(13'd4096, 8'h00);
		queue_random(16, 0);
		wait_idle();

		// two-tick frames so the flash bit of the frame counter turns over
		set_timing(0, 0, 2, 1, 2, 1, 1);
		push_write(13'd0, 8'hC3);
		push_write(ATTR_BASE, 8'hBA);
		queue_random(96, 10);
		wait_idle();

		// random phases over a spread of timings
		foreach (phase_plan[p]) begin
			case (phase_plan[p])
				PH_SMALL: begin
					lt = $urandom_range(48, 8);
					ft = $urandom_range(12, 2);
					set_timing(($urandom_range(3) == 0) ? $urandom_range(20) : 8 * $urandom_range(3),
						$urandom_range(4), $urandom_range(lt + 4, 1), $urandom_range(ft + 2, 1),
						lt, ft, $urandom_range(40, 1));
					queue_random(110, 25);
				end
				PH_DEEP: begin
					// one tick per line walks every screen row of the first cell column
					set_timing(0, 0, 1, 205, 1, 211, $urandom_range(500, 1));
					if (!hold_req)
						hold_req <= 1'b1;
					queue_random(300, 15);
				end
				PH_MAX: begin
					set_timing(504, 255, 1023, 511, 1023, 511, 65535);
					queue_random(110, 25);
				end
				PH_ZERO: begin
					set_timing(0, 0, 1, 1, 0, 0, 0);
					queue_random(110, 25);
				end
				PH_MIN: begin
					set_timing(0, 0, 1, 1, 1, 1, 1);
					queue_random(110, 25);
				end
				default: begin
					set_timing(48, 48, 352, 288, 448, 312, 1024);
					queue_random(110, 25);
				end
			endcase
			wait_idle();
		end

		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
